FILE: sv/giba_pkg.sv
package giba_pkg;
	localparam int MaxBoxes = 32;
	localparam int IdxW = $clog2(MaxBoxes);
	localparam int CntW = $clog2(MaxBoxes + 1);
	localparam logic [10:0] UnmatchedProb = 11'd563;
	localparam logic [10:0] ThrReset = 11'd102;
	localparam logic [14:0] LimReset = 15'd1280;

	typedef enum logic [1:0] {
		ACT_NEW   = 2'd0,
		ACT_LOAD  = 2'd1,
		ACT_QUERY = 2'd2
	} action_t;

	localparam logic CFG_THR = 1'b0;
	localparam logic CFG_LIM = 1'b1;

	typedef struct packed {
		logic        start;
		logic [33:0] dividend;
		logic [33:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [10:0] quotient;
	} div_rsp_t;
endpackage

FILE: sv/giba_div.sv
// Restoring divider: floor(dividend * 1024 / divisor) for dividend <= divisor,
// one quotient bit per cycle; done pulses as the last bit is registered.
module giba_div (
	input  logic                clk,
	input  logic                arst_n,
	input  giba_pkg::div_req_t  req,
	output giba_pkg::div_rsp_t  rsp
);
	logic [34:0] rem_q;
	logic [33:0] dvs_q;
	logic [10:0] quo_q;
	logic [3:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [35:0] trial;
	logic        qbit;
	logic [34:0] rem_nx;

	assign trial  = {1'b0, rem_q} - {2'd0, dvs_q};
	assign qbit   = !trial[35];
	assign rem_nx = qbit ? trial[34:0] : rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
			dvs_q  <= '0;
		end else begin
			done_q <= busy_q && !req.start && cnt_q == 4'd10;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 4'd0;
				rem_q  <= {1'b0, req.dividend};
				quo_q  <= '0;
				dvs_q  <= req.divisor;
			end else if (busy_q) begin
				// remainder stays below the divisor, so the shift never overflows
				cnt_q <= cnt_q + 4'd1;
				quo_q <= {quo_q[9:0], qbit};
				rem_q <= {rem_nx[33:0], 1'b0};
				if (cnt_q == 4'd10) busy_q <= 1'b0;
			end
		end
	end

	assign rsp = '{done: done_q, quotient: quo_q};
endmodule

FILE: sv/greedy_iou_box_association.sv
// New frame and load are taken and give no word. A query walks the table: used
// entries are skipped, unused ones without hypothesis are dropped after the read, a
// zero union bypasses the divider, and every other unused entry with a hypothesis
// goes through the shared 11-step divider.
// Throughput: one word at a time; in_stall is high while a query is in work or
// its result waits. Reset clears table count, used flags and config to defaults.
module greedy_iou_box_association (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [14:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic signed [15:0] cam_center_x,
	input  logic signed [15:0] cam_center_y,
	input  logic [14:0] cam_size_x,
	input  logic [14:0] cam_size_y,
	input  logic [10:0] cam_score,
	input  logic [7:0]  cam_class,
	input  logic        cam_has_hypothesis,
	input  logic [14:0] roi_min_x,
	input  logic [14:0] roi_min_y,
	input  logic [14:0] roi_max_x,
	input  logic [14:0] roi_max_y,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        matched,
	output logic [4:0]  match_index,
	output logic [7:0]  match_class,
	output logic [10:0] existence_prob,
	output logic [10:0] match_iou
);
	localparam int IW = giba_pkg::IdxW;
	localparam int CW = giba_pkg::CntW;

	typedef enum logic [2:0] {
		S_IDLE, S_RD, S_GEOM, S_AREA, S_DIV, S_CHK, S_FIN, S_OUT
	} state_t;

	state_t state_q;
	logic [61:0] box_mem [giba_pkg::MaxBoxes];
	logic [19:0] attr_mem [giba_pkg::MaxBoxes];
	logic [giba_pkg::MaxBoxes-1:0] used_q;
	logic [CW-1:0] count_q, idx_q;
	logic [10:0] thr_q;
	logic [14:0] lim_q;
	logic [61:0] box_q;
	logic [19:0] attr_q;
	logic signed [17:0] rx0_q, ry0_q, rx1_q, ry1_q;
	logic signed [17:0] rcx_q, rcy_q;
	logic [33:0] rarea_q;
	logic signed [18:0] iw_q, ih_q, dx_q, dy_q;
	logic [33:0] inter_q, uni_q, dsq_q;
	logic [10:0] iou_q;
	logic found_q;
	logic [IW-1:0] best_idx_q;
	logic [13:0] best_comb_q;
	logic [10:0] best_iou_q;
	logic [19:0] best_attr_q;
	giba_pkg::div_req_t dreq;
	giba_pkg::div_rsp_t drsp;

	giba_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	logic signed [17:0] cx2, cy2, bx0, bx1, by0, by1, lo_x, hi_x, lo_y, hi_y;
	logic signed [18:0] iw_c, ih_c;
	logic [33:0] barea_c, uni_c, limsq_c;
	logic [35:0] dsq_c;
	logic [13:0] comb_c;
	logic [IW-1:0] idx_lo;
	logic [11:0] prob_c;

	assign idx_lo = idx_q[IW-1:0];
	assign cx2 = {box_q[15], box_q[15:0], 1'b0};
	assign cy2 = {box_q[31], box_q[31:16], 1'b0};
	assign bx0 = cx2 - 18'(box_q[46:32]);
	assign bx1 = cx2 + 18'(box_q[46:32]);
	assign by0 = cy2 - 18'(box_q[61:47]);
	assign by1 = cy2 + 18'(box_q[61:47]);
	assign lo_x = (rx0_q > bx0) ? rx0_q : bx0;
	assign hi_x = (rx1_q < bx1) ? rx1_q : bx1;
	assign lo_y = (ry0_q > by0) ? ry0_q : by0;
	assign hi_y = (ry1_q < by1) ? ry1_q : by1;
	assign iw_c = 19'(hi_x) - 19'(lo_x);
	assign ih_c = 19'(hi_y) - 19'(lo_y);
	assign barea_c = 34'({box_q[46:32], 1'b0} * {box_q[61:47], 1'b0});
	assign uni_c = rarea_q + barea_c - inter_q;
	assign limsq_c = 34'({lim_q, 1'b0} * {lim_q, 1'b0});
	assign dsq_c = 36'(dx_q * dx_q) + 36'(dy_q * dy_q);
	assign comb_c = 14'(iou_q * 7) + 14'(attr_q[10:0] * 3);
	assign prob_c = (12'd1025 + 12'(best_attr_q[10:0])) >> 1;

	assign in_stall = (state_q != S_IDLE);

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid && action == giba_pkg::ACT_LOAD
			&& count_q < CW'(giba_pkg::MaxBoxes)) begin
			box_mem[count_q[IW-1:0]] <= {cam_size_y, cam_size_x, cam_center_y, cam_center_x};
			attr_mem[count_q[IW-1:0]] <= {cam_has_hypothesis, cam_class, cam_score};
		end
		box_q  <= box_mem[idx_lo];
		attr_q <= attr_mem[idx_lo];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			used_q    <= '0;
			count_q   <= '0;
			idx_q     <= '0;
			thr_q     <= giba_pkg::ThrReset;
			lim_q     <= giba_pkg::LimReset;
			out_valid <= 1'b0;
			found_q   <= 1'b0;
			dreq      <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == giba_pkg::CFG_THR) thr_q <= cfg_data[10:0];
				else lim_q <= cfg_data;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						case (action)
							giba_pkg::ACT_NEW: begin
								count_q <= '0;
								used_q  <= '0;
							end
							giba_pkg::ACT_LOAD: begin
								if (count_q < CW'(giba_pkg::MaxBoxes)) begin
									used_q[count_q[IW-1:0]] <= 1'b0;
									count_q <= count_q + CW'(1);
								end
							end
							giba_pkg::ACT_QUERY: begin
								rx0_q <= {3'd0, roi_min_x} <<< 1;
								ry0_q <= {3'd0, roi_min_y} <<< 1;
								rx1_q <= {3'd0, roi_max_x} <<< 1;
								ry1_q <= {3'd0, roi_max_y} <<< 1;
								rcx_q <= 18'(roi_min_x) + 18'(roi_max_x);
								rcy_q <= 18'(roi_min_y) + 18'(roi_max_y);
								rarea_q <= 34'((roi_max_x > roi_min_x ? 16'(roi_max_x - roi_min_x) : 16'd0)
									* (roi_max_y > roi_min_y ? 16'(roi_max_y - roi_min_y) : 16'd0)) << 2;
								idx_q   <= '0;
								found_q <= 1'b0;
								best_idx_q  <= '0;
								best_comb_q <= '0;
								best_iou_q  <= '0;
								best_attr_q <= '0;
								state_q <= S_RD;
							end
							default: ;
						endcase
					end
				end
				S_RD: begin
					if (idx_q >= count_q) state_q <= S_FIN;
					else if (used_q[idx_lo]) idx_q <= idx_q + CW'(1);
					else state_q <= S_GEOM;
				end
				S_GEOM: begin
					if (!attr_q[19]) begin
						idx_q <= idx_q + CW'(1);
						state_q <= S_RD;
					end else begin
						iw_q <= iw_c[18] ? 19'sd0 : iw_c;
						ih_q <= ih_c[18] ? 19'sd0 : ih_c;
						dx_q <= 19'(rcx_q) - 19'(cx2);
						dy_q <= 19'(rcy_q) - 19'(cy2);
						state_q <= S_AREA;
					end
				end
				S_AREA: begin
					inter_q <= 34'(iw_q * ih_q);
					dsq_q   <= '0;
					state_q <= S_DIV;
					dreq.start <= 1'b0;
					uni_q <= '0;
				end
				S_DIV: begin
					if (!dreq.start && uni_q == '0 && !drsp.done && dsq_q == '0) begin
						uni_q <= uni_c;
						dreq.start <= (uni_c != '0);
						dreq.dividend <= inter_q;
						dreq.divisor <= uni_c;
						if (uni_c == '0) begin
							dsq_q <= 34'(dsq_c > 36'(limsq_c));
							iou_q <= '0;
							state_q <= S_CHK;
						end else dsq_q <= {33'd0, 1'b1} | 34'(dsq_c > 36'(limsq_c)) << 1;
					end else begin
						dreq.start <= 1'b0;
						if (drsp.done) begin
							iou_q <= drsp.quotient;
							dsq_q <= dsq_q >> 1;
							state_q <= S_CHK;
						end
					end
				end
				S_CHK: begin
					if (iou_q >= thr_q && dsq_q[0] == 1'b0
						&& (!found_q || comb_c > best_comb_q)) begin
						found_q <= 1'b1;
						best_comb_q <= comb_c;
						best_idx_q  <= idx_lo;
						best_iou_q  <= iou_q;
						best_attr_q <= attr_q;
					end
					uni_q <= '0;
					dsq_q <= '0;
					idx_q <= idx_q + CW'(1);
					state_q <= S_RD;
				end
				S_FIN: begin
					out_valid <= 1'b1;
					matched <= found_q;
					if (found_q) begin
						used_q[best_idx_q] <= 1'b1;
						match_index <= 5'(best_idx_q);
						match_class <= best_attr_q[18:11];
						existence_prob <= (prob_c > 12'd1024) ? 11'd1024 : prob_c[10:0];
						match_iou <= best_iou_q;
					end else begin
						match_index <= '0;
						match_class <= '0;
						existence_prob <= giba_pkg::UnmatchedProb;
						match_iou <= '0;
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_stall) begin
						out_valid <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_out_only_in_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == S_OUT) else $error("out_valid outside result state");
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(giba_pkg::MaxBoxes)) else $error("entry count overflow");
	a_no_unmatched_iou: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !matched) |-> match_iou == 11'd0) else $error("iou on miss");
endmodule
